### rtl/prng_rotation_stream_cipher_core_defines.svh
// ----------------------------------------------------------------------------
// prng rotation stream cipher assertion macros
// shared concurrent assertion wrappers, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef PRNG_ROTATION_STREAM_CIPHER_CORE_DEFINES_SVH
`define PRNG_ROTATION_STREAM_CIPHER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prc assertion failed in the same cycle");

// consequent checked in the cycle after the antecedent
`define PRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prc assertion failed one cycle later");

`endif

### rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// constants, types and the key generator step shared by the cipher modules
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int BYTE_W   = 8;
    localparam int KEY_W    = 17;
    localparam int SEED_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [KEY_W-1:0] GEN_MULT  = 17'd75;
    localparam logic [KEY_W-1:0] GEN_MOD   = 17'd65537;
    localparam logic [KEY_W-1:0] KEY_RESET = 17'd75;   // one step from seed 1
    localparam logic [KEY_W-1:0] KEY_MAX   = 17'd65536;

    localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'd127;
    localparam logic [BYTE_W-1:0] PRINT_SPAN = 8'd96;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SEED_W-1:0] t_seed;

    // control from the top level to the key generator
    typedef struct packed {
        logic  load;      // restart from seed
        logic  advance;   // one step per accepted beat
        t_seed seed;
    } t_key_ctrl;

    // one generator step: key * 75 mod 65537 via low half minus high half
    function automatic t_key gen_step(input t_key k);
        logic [23:0] p;
        logic [15:0] lo;
        logic [7:0]  hi;
        t_key        res;
        p  = {7'b0, k} * {7'b0, GEN_MULT};
        lo = p[15:0];
        hi = p[23:16];
        if (lo >= {8'b0, hi}) begin
            res = {1'b0, lo - {8'b0, hi}};
        end else begin
            res = {1'b0, lo} + GEN_MOD - {9'b0, hi};
        end
        return res;
    endfunction

endpackage

### rtl/prc_in_if.sv
// ----------------------------------------------------------------------------
// prc_in_if
// input byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface prc_in_if;
    import prc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/prc_out_if.sv
// ----------------------------------------------------------------------------
// prc_out_if
// result byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface prc_out_if;
    import prc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

### rtl/prc_keygen.sv
// ----------------------------------------------------------------------------
// prc_keygen
// key register with one shared generator step for seeding and advancing
// ----------------------------------------------------------------------------
module prc_keygen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prc_pkg::t_key_ctrl i_ctrl,
    output prc_pkg::t_key      o_key
);
    import prc_pkg::*;

    t_key r_key;
    t_key n_key;
    t_key step_in;

    // one multiplier, fed from the seed on a load
    assign step_in = i_ctrl.load ? {1'b0, i_ctrl.seed} : r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.load || i_ctrl.advance) begin
            n_key = gen_step(step_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;
endmodule

### rtl/prc_rotate.sv
// ----------------------------------------------------------------------------
// prc_rotate
// rotates a printable byte by key mod 96, other bytes pass through
// ----------------------------------------------------------------------------
module prc_rotate (
    input  prc_pkg::t_byte i_byte,
    input  prc_pkg::t_key  i_key,
    input  logic           i_decrypt,
    output prc_pkg::t_byte o_byte
);
    import prc_pkg::*;

    // 12-bit value mod 3: base-4 digits each weigh 1 mod 3
    function automatic logic [1:0] mod3_12(input logic [11:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] r;
        s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
          + 5'(v[9:8]) + 5'(v[11:10]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            r = t - 3'd6;
        end else if (t >= 3'd3) begin
            r = t - 3'd3;
        end else begin
            r = t;
        end
        return r[1:0];
    endfunction

    logic [6:0] shift;    // key mod 96 = (key/32 mod 3)*32 + key mod 32
    logic [6:0] pos;
    logic [7:0] sum;
    logic [7:0] wrapped;
    logic       printable;

    assign shift     = {mod3_12(i_key[16:5]), i_key[4:0]};
    assign printable = (i_byte >= PRINT_LOW) && (i_byte <= PRINT_HIGH);
    assign pos       = 7'(i_byte - PRINT_LOW);

    always_comb begin
        if (i_decrypt) begin
            sum = {1'b0, pos} + PRINT_SPAN - {1'b0, shift};
        end else begin
            sum = {1'b0, pos} + {1'b0, shift};
        end
        wrapped = (sum >= PRINT_SPAN) ? sum - PRINT_SPAN : sum;
    end

    assign o_byte = printable ? wrapped + PRINT_LOW : i_byte;
endmodule

### rtl/prng_rotation_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// prng_rotation_stream_cipher_core
// byte stream cipher: printable codes rotated by a mod 65537 key generator
// ----------------------------------------------------------------------------
// usage
//   input channel i_in_ch carries one data_byte per beat, output channel
//   o_out_ch returns one result_byte per beat, in order, one for one
//   codes 32..127 are rotated within that range by key mod 96, forward when
//   decrypt_mode is 0 and backward when it is 1; all other bytes pass as is
//   the key steps once (key * 75 mod 65537) after every accepted beat
//   a beat accepted at one edge is offered on o_out_ch from the next cycle;
//   throughput one beat per cycle while the receiver is ready, set by the
//   single result register behind the generator step and the rotate logic
//   i_in_ch.ready is high whenever the result register is empty or is
//   being emptied, so a stalled receiver holds one result and then stops
//   the input side; nothing is dropped
//   configuration: i_cfg_we with i_cfg_idx 0 loads start_seed (the key
//   restarts one step after the seed; a seed of 0 is ignored), index 1
//   sets decrypt_mode; other indexes do nothing; write only while idle
//   reset (synchronous, active low): key 75 as for seed 1, encrypt mode,
//   output empty
// ----------------------------------------------------------------------------
`include "prng_rotation_stream_cipher_core_defines.svh"

module prng_rotation_stream_cipher_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    prc_in_if.sink                       i_in_ch,
    prc_out_if.source                    o_out_ch,
    input  logic                         i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  prc_pkg::t_seed               i_cfg_wdata
);
    import prc_pkg::*;

    logic      r_mode;
    logic      r_out_valid;
    t_byte     r_out_byte;
    logic      n_mode;

    logic      in_acc;
    logic      seed_wr;
    t_key      key;
    t_byte     rot_byte;
    t_key_ctrl key_ctrl;

    // input taken whenever the result slot is free or drains this cycle
    assign i_in_ch.ready = !r_out_valid || o_out_ch.ready;
    assign in_acc        = i_in_ch.valid && i_in_ch.ready;

    // register decode
    always_comb begin
        seed_wr = 1'b0;
        n_mode  = r_mode;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_SEED: seed_wr = (i_cfg_wdata != '0);
                CFG_IDX_MODE: n_mode  = i_cfg_wdata[0];
                default:      seed_wr = 1'b0;
            endcase
        end
    end

    assign key_ctrl = '{load: seed_wr, advance: in_acc, seed: i_cfg_wdata};

    prc_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (key_ctrl),
        .o_key   (key)
    );

    prc_rotate u_rotate (
        .i_byte    (i_in_ch.data_byte),
        .i_key     (key),
        .i_decrypt (r_mode),
        .o_byte    (rot_byte)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode <= n_mode;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_byte <= rot_byte;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.result_byte = r_out_byte;

    // checks
    `PRC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, i_in_ch.ready)
    `PRC_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, in_acc, r_out_valid)
    `PRC_ASSERT_NOW(a_key_in_range, i_clk, i_rst_n, 1'b1, (key != '0) && (key <= KEY_MAX))
    `PRC_ASSERT_NEXT(a_passthrough, i_clk, i_rst_n, in_acc && ((i_in_ch.data_byte < PRINT_LOW) || (i_in_ch.data_byte > PRINT_HIGH)), r_out_byte == $past(i_in_ch.data_byte))
endmodule

### sim/tb_prng_rotation_stream_cipher_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prng_rotation_stream_cipher_core
// self-checking bench for the rotation stream cipher: a scoreboard keeps its
// own key generator and rotation, predicts every result byte from the
// accepted input beats and register writes, and checks the output in order
// ----------------------------------------------------------------------------
module tb_prng_rotation_stream_cipher_core;
    import prc_pkg::*;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BYTES     = 66;
    localparam int PRESSURE_PHASE  = 3;
    localparam int NO_IDLE_PHASE   = 5;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_LIMIT     = 2000;

    // ------------------------------------------------------------------------
    // scoreboard: its own copy of the key, seed and mode, plus the queue of
    // result bytes still owed by the block
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        t_key  key;
        t_seed seed;
        logic  decrypt;
        t_byte expected_bytes[$];
        int    errors;

        function new();
            seed    = 16'd1;
            decrypt = 1'b0;
            key     = advance_key(17'd1);
            errors  = 0;
        endfunction

        // key * 75 mod 65537, taken directly as a remainder
        function t_key advance_key(input t_key k);
            int unsigned p;
            p = int'(k) * int'(GEN_MULT);
            return t_key'(p % int'(GEN_MOD));
        endfunction

        // rotate printable codes within 32..127 by key mod 96
        function t_byte rotate_printable(input t_byte b, input t_key k, input logic back);
            int unsigned shift;
            int unsigned pos;
            if (b < PRINT_LOW || b > PRINT_HIGH) begin
                return b;
            end
            shift = int'(k) % int'(PRINT_SPAN);
            pos   = int'(b) - int'(PRINT_LOW);
            if (back) begin
                pos = (pos + int'(PRINT_SPAN) - shift) % int'(PRINT_SPAN);
            end else begin
                pos = (pos + shift) % int'(PRINT_SPAN);
            end
            return t_byte'(pos + int'(PRINT_LOW));
        endfunction

        function void apply_write(input logic [CFG_IDX_W-1:0] idx, input t_seed value);
            if (idx == CFG_IDX_SEED) begin
                if (value != '0) begin
                    seed = value;
                    key  = advance_key(t_key'(value));
                end
            end else if (idx == CFG_IDX_MODE) begin
                decrypt = value[0];
            end
        endfunction

        function void note_byte(input t_byte b);
            expected_bytes.push_back(rotate_printable(b, key, decrypt));
            key = advance_key(key);
        endfunction

        function void check_result(input t_byte actual);
            t_byte want;
            if (expected_bytes.size() == 0) begin
                $error("result_byte %02h arrived with nothing expected", actual);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (actual !== want) begin
                $error("result_byte expected %02h actual %02h", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    logic  [CFG_IDX_W-1:0] i_cfg_idx;
    t_seed i_cfg_wdata;

    prc_in_if  in_ch ();
    prc_out_if out_ch ();

    cipher_scoreboard sb = new();

    // idling controls for the sender and the receiver, set by the main sequence
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int rx_hold_cycles = 0;

    prng_rotation_stream_cipher_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // mostly printable text, with control codes and high bytes mixed in
    function automatic t_byte pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return t_byte'($urandom_range(32, 127));
        end else if (r < 82) begin
            return t_byte'($urandom_range(0, 31));
        end else if (r < 94) begin
            return t_byte'($urandom_range(128, 255));
        end
        return t_byte'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, where the drivers
    // (which move at the falling edge) are settled
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.result_byte);
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_byte(in_ch.data_byte);
            end
            if (i_cfg_we) begin
                sb.apply_write(i_cfg_idx, i_cfg_wdata);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure, a no-stall mode, and a long hold-off
    // counted down here so the block fills and stops taking input beats
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end else if (!rx_gaps_on) begin
                out_ch.ready <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else if ($urandom_range(0, 99) < 70) begin
                out_ch.ready <= 1'b1;
            end else begin
                // this cycle counts as the first of the stall
                out_ch.ready <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: called at a falling edge, returns at the falling edge after the
    // beat is taken; valid stays high into the next beat when there is no gap
    // ------------------------------------------------------------------------
    task automatic send_byte(input t_byte b);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid and let the block drain before touching the registers
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // register write, one cycle wide, with i_cfg_we low again before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_seed value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_list(input t_byte list[]);
        foreach (list[i]) begin
            send_byte(list[i]);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int drain;
        int r;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_IDX_SEED;
        i_cfg_wdata     = '0;
        i_rst_n         = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset key and encrypt mode: range edges, control codes, high bytes
        send_list('{8'h00, 8'h1F, 8'h20, 8'h21, 8'h7E, 8'h7F, 8'h80, 8'hFF});

        // decrypt, key sequence carries on from where it was
        write_reg(CFG_IDX_MODE, 16'h0001);
        send_list('{8'h20, 8'h7F, 8'h41, 8'hAA});

        // zero seed and unused indexes must leave everything as it was
        write_reg(CFG_IDX_SEED, 16'h0000);
        write_reg(CFG_IDX_SPARE_A, 16'hFFFF);
        write_reg(CFG_IDX_SPARE_B, 16'h0000);
        send_list('{8'h55, 8'h7F, 8'h20});

        // largest seed, encrypt; only bit 0 of the mode write counts
        write_reg(CFG_IDX_SEED, 16'hFFFF);
        write_reg(CFG_IDX_MODE, 16'hFFFE);
        send_list('{8'h7F, 8'h20, 8'h5A, 8'hFF});

        // smallest seed again, decrypt
        write_reg(CFG_IDX_SEED, 16'h0001);
        write_reg(CFG_IDX_MODE, 16'h0001);
        send_list('{8'h20, 8'h7F, 8'h01});

        // random phases, each under a fresh setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 4);
            case (r)
                0: write_reg(CFG_IDX_SEED, 16'h0001);
                1: write_reg(CFG_IDX_SEED, 16'hFFFF);
                2: write_reg(CFG_IDX_SEED, 16'h0000);
                default: write_reg(CFG_IDX_SEED, t_seed'($urandom_range(1, 65535)));
            endcase
            write_reg(CFG_IDX_MODE, t_seed'($urandom));
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                          t_seed'($urandom));
            end

            tx_gaps_on = 1'b1;
            rx_gaps_on = 1'b1;
            if (p == PRESSURE_PHASE) begin
                // receiver holds off while the sender keeps offering beats
                tx_gaps_on     = 1'b0;
                rx_hold_cycles = LONG_HOLD;
            end else if (p == NO_IDLE_PHASE) begin
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
            end

            for (int i = 0; i < PHASE_BYTES; i++) begin
                send_byte(pick_byte());
            end
            wait_idle();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;

        // bounded drain: anything still owed after this counts as a failure
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain++;
        end
        if (sb.pending() != 0) begin
            $error("result_byte: %0d expected beats never arrived", sb.pending());
            sb.errors++;
        end
        repeat (5) @(negedge i_clk);

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/prc_pkg.sv
rtl/prc_in_if.sv
rtl/prc_out_if.sv
rtl/prc_keygen.sv
rtl/prc_rotate.sv
rtl/prng_rotation_stream_cipher_core.sv
sim/tb_prng_rotation_stream_cipher_core.sv
